FILE: hdl/ecr_pkg.sv
package ecr_pkg;

  localparam int ENTRY_W           = 42;
  localparam int ELEV_W            = 18;
  localparam int CHAN_W            = 8;
  localparam int SAMPLE_W          = 16;
  localparam int NUM_REGS          = 6;
  localparam int MAX_POINTS        = 8;
  localparam int CFG_INDEX_W       = 3;
  localparam int RAMP_POINTS_DEF   = 6;
  localparam int FRACTION_BITS_DEF = 16;
  localparam int MID_DEPTH         = 2;
  localparam int OUT_DEPTH         = 2;

  localparam int ELEV_LSB = 24;
  localparam int BLUE_LSB = 16;
  localparam int GREEN_LSB = 8;
  localparam int RED_LSB = 0;

  localparam logic signed [SAMPLE_W-1:0] FLOOR_ELEV = -16'sd10;
  localparam logic [CHAN_W-1:0]          TINT_ADD   = 8'd90;
  localparam logic [CHAN_W:0]            TINT_LIMIT = 9'd255;
  localparam logic signed [SAMPLE_W-1:0] BLUE_BELOW  = 16'sd10;
  localparam logic signed [SAMPLE_W-1:0] GREEN_BELOW = 16'sd50;
  localparam logic signed [SAMPLE_W-1:0] RED_BELOW   = 16'sd100;

  // entries past the register list repeat the last default breakpoint
  localparam logic [MAX_POINTS-1:0][ENTRY_W-1:0] RAMP_DEFAULTS = {
    42'd13438203020, 42'd13438203020, 42'd13438203020, 42'd6725353130,
    42'd5043707080, 42'd1352071910, 42'd24042606, 42'd4397991762478
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] height_sample;
    logic                       sample_inside;
    logic [CHAN_W-1:0]          photo_blue;
    logic [CHAN_W-1:0]          photo_green;
    logic [CHAN_W-1:0]          photo_red;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] ramp_blue;
    logic [CHAN_W-1:0] ramp_green;
    logic [CHAN_W-1:0] ramp_red;
    logic [CHAN_W-1:0] tint_blue;
    logic [CHAN_W-1:0] tint_green;
    logic [CHAN_W-1:0] tint_red;
  } out_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } colour_t;

  // classified item handed from front to back
  typedef struct packed {
    colour_t           lo;
    colour_t           hi;
    logic [ELEV_W-1:0] num;
    logic [ELEV_W-1:0] den;
    colour_t           tint;
  } mid_item_t;

  typedef struct packed {
    logic hold;
    logic mult_valid;
    logic div_last_valid;
    logic div_rem_ok;
  } back_status_t;

  function automatic colour_t entry_colour(logic [ENTRY_W-1:0] entry);
    colour_t c;
    c.blue  = entry[BLUE_LSB +: CHAN_W];
    c.green = entry[GREEN_LSB +: CHAN_W];
    c.red   = entry[RED_LSB +: CHAN_W];
    return c;
  endfunction

endpackage

FILE: hdl/ecr_fifo.sv
module ecr_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hdl/ecr_front.sv
module ecr_front #(
  parameter int RAMP_POINTS = ecr_pkg::RAMP_POINTS_DEF
) (
  input  ecr_pkg::in_item_t                                  item_i,
  input  logic [RAMP_POINTS-1:0][ecr_pkg::ENTRY_W-1:0]       ramp_i,
  output ecr_pkg::mid_item_t                                 mid_o
);
  import ecr_pkg::*;

  logic signed [SAMPLE_W-1:0] elev;
  logic signed [ELEV_W-1:0]   quarter;
  logic signed [ELEV_W-1:0]   first_elev, last_elev;
  logic signed [ELEV_W-1:0]   seg_a, seg_b;
  logic signed [ELEV_W:0]     num_wide, den_wide;
  logic [ENTRY_W-1:0]         lo_entry, hi_entry;
  logic                       found, blend_on;
  logic [CHAN_W:0]            sum_b, sum_g, sum_r;

  assign elev       = item_i.sample_inside ? item_i.height_sample : FLOOR_ELEV;
  assign quarter    = {elev, 2'b00};
  assign first_elev = ramp_i[0][ELEV_LSB +: ELEV_W];
  assign last_elev  = ramp_i[RAMP_POINTS-1][ELEV_LSB +: ELEV_W];

  always_comb begin
    found    = 1'b0;
    blend_on = 1'b0;
    lo_entry = ramp_i[RAMP_POINTS-1];
    hi_entry = ramp_i[RAMP_POINTS-1];
    seg_a    = '0;
    seg_b    = '0;
    if (quarter < first_elev) begin
      lo_entry = ramp_i[0];
      hi_entry = ramp_i[0];
    end else if (quarter > last_elev) begin
      lo_entry = ramp_i[RAMP_POINTS-1];
      hi_entry = ramp_i[RAMP_POINTS-1];
    end else begin
      // first segment whose upper breakpoint lies above the sample
      for (int x = 0; x < RAMP_POINTS - 1; x++) begin
        if (!found && (quarter < signed'(ramp_i[x+1][ELEV_LSB +: ELEV_W]))) begin
          found    = 1'b1;
          blend_on = 1'b1;
          lo_entry = ramp_i[x];
          hi_entry = ramp_i[x+1];
          seg_a    = ramp_i[x][ELEV_LSB +: ELEV_W];
          seg_b    = ramp_i[x+1][ELEV_LSB +: ELEV_W];
        end
      end
    end
  end

  assign num_wide = {quarter[ELEV_W-1], quarter} - {seg_a[ELEV_W-1], seg_a};
  assign den_wide = {seg_b[ELEV_W-1], seg_b} - {seg_a[ELEV_W-1], seg_a};

  // no blend or sample at segment start: 0/1 gives a zero fraction
  always_comb begin
    mid_o.lo = entry_colour(lo_entry);
    mid_o.hi = entry_colour(hi_entry);
    if (blend_on && (quarter > seg_a)) begin
      mid_o.num = num_wide[ELEV_W-1:0];
      mid_o.den = den_wide[ELEV_W-1:0];
    end else begin
      mid_o.num = '0;
      mid_o.den = ELEV_W'(1);
    end
  end

  assign sum_b = {1'b0, item_i.photo_blue}  + {1'b0, TINT_ADD};
  assign sum_g = {1'b0, item_i.photo_green} + {1'b0, TINT_ADD};
  assign sum_r = {1'b0, item_i.photo_red}   + {1'b0, TINT_ADD};

  always_comb begin
    mid_o.tint.blue  = item_i.photo_blue;
    mid_o.tint.green = item_i.photo_green;
    mid_o.tint.red   = item_i.photo_red;
    if (elev < BLUE_BELOW) begin
      if (sum_b < TINT_LIMIT) mid_o.tint.blue = sum_b[CHAN_W-1:0];
    end else if (elev < GREEN_BELOW) begin
      if (sum_g < TINT_LIMIT) mid_o.tint.green = sum_g[CHAN_W-1:0];
    end else if (elev < RED_BELOW) begin
      if (sum_r < TINT_LIMIT) mid_o.tint.red = sum_r[CHAN_W-1:0];
    end
  end

endmodule

FILE: hdl/ecr_back.sv
module ecr_back #(
  parameter int FRACTION_BITS = ecr_pkg::FRACTION_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  mid_valid_i,
  input  ecr_pkg::mid_item_t    mid_i,
  output logic                  mid_pop_o,
  input  logic                  out_full_i,
  output logic                  out_push_o,
  output ecr_pkg::out_item_t    out_o,
  output ecr_pkg::back_status_t status_o
);
  import ecr_pkg::*;

  localparam int PROD_W = CHAN_W + FRACTION_BITS + 1;

  typedef struct packed {
    logic [ELEV_W-1:0]        rem;
    logic [ELEV_W-1:0]        den;
    logic [FRACTION_BITS-1:0] quo;
    colour_t                  lo;
    colour_t                  hi;
    colour_t                  tint;
  } div_stage_t;

  div_stage_t               div_src [FRACTION_BITS];
  div_stage_t               div_d   [FRACTION_BITS];
  div_stage_t               div_q   [FRACTION_BITS];
  logic [FRACTION_BITS-1:0] div_valid_q;
  out_item_t                mult_d, mult_q;
  logic                     mult_valid_q;
  logic                     adv;
  logic [FRACTION_BITS-1:0] frac;
  logic [FRACTION_BITS:0]   frac_inv;
  div_stage_t               last;

  function automatic logic [CHAN_W-1:0] blend_chan(logic [CHAN_W-1:0] c0,
                                                   logic [CHAN_W-1:0] c1,
                                                   logic [FRACTION_BITS:0] w0,
                                                   logic [FRACTION_BITS-1:0] w1);
    logic [PROD_W-1:0] acc;
    acc = PROD_W'(c0) * PROD_W'(w0) + PROD_W'(c1) * PROD_W'(w1);
    return acc[FRACTION_BITS +: CHAN_W];
  endfunction

  // whole pipeline holds while the finished result cannot leave
  assign adv        = !(mult_valid_q && out_full_i);
  assign mid_pop_o  = adv && mid_valid_i;
  assign out_push_o = adv && mult_valid_q;
  assign out_o      = mult_q;

  always_comb begin
    div_src[0].rem  = mid_i.num;
    div_src[0].den  = mid_i.den;
    div_src[0].quo  = '0;
    div_src[0].lo   = mid_i.lo;
    div_src[0].hi   = mid_i.hi;
    div_src[0].tint = mid_i.tint;
    for (int k = 1; k < FRACTION_BITS; k++) begin
      div_src[k] = div_q[k-1];
    end
  end

  // restoring division, one quotient bit per stage; remainder stays below den
  always_comb begin
    logic [ELEV_W:0] twice;
    for (int k = 0; k < FRACTION_BITS; k++) begin
      div_d[k] = div_src[k];
      twice    = {div_src[k].rem, 1'b0};
      if (twice >= {1'b0, div_src[k].den}) begin
        twice          = twice - {1'b0, div_src[k].den};
        div_d[k].quo   = {div_src[k].quo[FRACTION_BITS-2:0], 1'b1};
      end else begin
        div_d[k].quo   = {div_src[k].quo[FRACTION_BITS-2:0], 1'b0};
      end
      div_d[k].rem = twice[ELEV_W-1:0];
    end
  end

  assign last     = div_q[FRACTION_BITS-1];
  assign frac     = last.quo;
  assign frac_inv = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, frac};

  always_comb begin
    mult_d.ramp_blue  = blend_chan(last.lo.blue,  last.hi.blue,  frac_inv, frac);
    mult_d.ramp_green = blend_chan(last.lo.green, last.hi.green, frac_inv, frac);
    mult_d.ramp_red   = blend_chan(last.lo.red,   last.hi.red,   frac_inv, frac);
    mult_d.tint_blue  = last.tint.blue;
    mult_d.tint_green = last.tint.green;
    mult_d.tint_red   = last.tint.red;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_valid_q  <= '0;
      mult_valid_q <= 1'b0;
    end else if (adv) begin
      div_valid_q  <= {div_valid_q[FRACTION_BITS-2:0], mid_valid_i};
      mult_valid_q <= div_valid_q[FRACTION_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < FRACTION_BITS; k++) begin
        div_q[k] <= div_d[k];
      end
      mult_q <= mult_d;
    end
  end

  assign status_o.hold           = !adv;
  assign status_o.mult_valid     = mult_valid_q;
  assign status_o.div_last_valid = div_valid_q[FRACTION_BITS-1];
  assign status_o.div_rem_ok     = (last.rem < last.den);

endmodule

FILE: hdl/elevation_color_ramp_with_flood_tint_unit.sv
// channel   direction  handshake                 payload
// input     in         push / full               in_item_i  (in_item_t)
// result    out        empty / pop               out_item_o (out_item_t)
// config    in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one item per clock sustained while pop keeps the output queue from filling
// the back end holds a restoring divider, one fraction bit per stage
// reset loads the default ramp into the breakpoint registers and empties both queues
// holding pop freezes the back pipeline once the output queue fills; the front keeps
// taking items until the two-entry queue between front and back fills, then full rises
module elevation_color_ramp_with_flood_tint_unit #(
  parameter int RAMP_POINTS   = ecr_pkg::RAMP_POINTS_DEF,
  parameter int FRACTION_BITS = ecr_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  ecr_pkg::in_item_t               in_item_i,
  output logic                            empty,
  input  logic                            pop,
  output ecr_pkg::out_item_t              out_item_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ecr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [ecr_pkg::ENTRY_W-1:0]     cfg_data_i
);
  import ecr_pkg::*;

  logic [RAMP_POINTS-1:0][ENTRY_W-1:0] ramp_q;
  mid_item_t    mid_in, mid_head;
  logic         mid_empty, mid_pop;
  out_item_t    back_item;
  logic         out_push, out_full;
  back_status_t back_st;

  assign cfg_ready_o = 1'b1;

  // breakpoints without a register keep their default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RAMP_POINTS; k++) begin
        ramp_q[k] <= RAMP_DEFAULTS[k];
      end
    end else if (cfg_valid_i) begin
      for (int k = 0; k < RAMP_POINTS; k++) begin
        if ((k < NUM_REGS) && (cfg_index_i == CFG_INDEX_W'(k))) begin
          ramp_q[k] <= cfg_data_i;
        end
      end
    end
  end

  ecr_front #(
    .RAMP_POINTS(RAMP_POINTS)
  ) u_front (
    .item_i(in_item_i),
    .ramp_i(ramp_q),
    .mid_o (mid_in)
  );

  ecr_fifo #(
    .WIDTH($bits(mid_item_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (mid_in),
    .full_o (full),
    .pop_i  (mid_pop),
    .data_o (mid_head),
    .empty_o(mid_empty)
  );

  ecr_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_valid_i(!mid_empty),
    .mid_i      (mid_head),
    .mid_pop_o  (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_o      (back_item),
    .status_o   (back_st)
  );

  ecr_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (back_item),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (out_item_o),
    .empty_o(empty)
  );

  // a held finished result stays put until the output queue has room
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_st.mult_valid && back_st.hold) |=> (back_st.mult_valid && $stable(back_item)))
    else $error("finished result changed while held");

  // divider remainder must end below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.div_last_valid |-> back_st.div_rem_ok)
    else $error("divider remainder not below divisor");

  // flood tint touches at most one channel of a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> ($countones({mid_in.tint.blue != in_item_i.photo_blue,
                                     mid_in.tint.green != in_item_i.photo_green,
                                     mid_in.tint.red != in_item_i.photo_red}) <= 1))
    else $error("tint applied to more than one channel");

  // back end only stalls when the output queue is full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_st.hold |-> (out_full && back_st.mult_valid))
    else $error("back pipeline stalled without cause");

endmodule
